[design/ansi_sgr_stream_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// ANSI SGR stream decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef ANSI_SGR_STREAM_DECODER_UNIT_DEFINES_SVH
`define ANSI_SGR_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define ASGR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("asgr assertion failed");

// next-cycle implication
`define ASGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("asgr assertion failed");

`endif

[design/asgr_pkg.sv]
// ----------------------------------------------------------------------------
// ANSI SGR stream decoder package
// Types, character codes, SGR codes and the SGR code apply function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asgr_pkg;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_CSI,
		MODE_PARAMS
	} mode_t;

	typedef struct packed {
		logic [4:0] fg;
		logic [4:0] bg;
		logic       bold;
	} style_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
		style_t     style;
		logic       last;
	} res_t;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_J      = 8'h4A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic       KIND_CHAR  = 1'b0;
	localparam logic       KIND_CLEAR = 1'b1;

	localparam logic [4:0] COLOUR_DEF = 5'd16;

	localparam int unsigned FIELD_W = 31;
	localparam int unsigned PROD_W  = 35;

	localparam logic [6:0] SGR_RESET  = 7'd0;
	localparam logic [6:0] SGR_BOLD   = 7'd1;
	localparam logic [6:0] SGR_FG_LO  = 7'd30;
	localparam logic [6:0] SGR_FG_HI  = 7'd37;
	localparam logic [6:0] SGR_FG_DEF = 7'd39;
	localparam logic [6:0] SGR_BG_LO  = 7'd40;
	localparam logic [6:0] SGR_BG_HI  = 7'd47;
	localparam logic [6:0] SGR_BG_DEF = 7'd49;
	localparam logic [6:0] SGR_FGB_LO = 7'd90;
	localparam logic [6:0] SGR_FGB_HI = 7'd97;
	localparam logic [6:0] SGR_BGB_LO = 7'd100;
	localparam logic [6:0] SGR_BGB_HI = 7'd107;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	function automatic style_t asgr_apply(input style_t s, input logic [FIELD_W-1:0] v);
		style_t     r;
		logic [6:0] lo;
		r  = s;
		lo = v[6:0];
		if (v[FIELD_W-1:7] == '0) begin
			unique case (lo) inside
				SGR_RESET: begin
					r.fg   = COLOUR_DEF;
					r.bg   = COLOUR_DEF;
					r.bold = 1'b0;
				end
				SGR_BOLD:               r.bold = 1'b1;
				[SGR_FG_LO:SGR_FG_HI]:  r.fg = {1'b0, 4'(lo - SGR_FG_LO)};
				SGR_FG_DEF:             r.fg = COLOUR_DEF;
				[SGR_BG_LO:SGR_BG_HI]:  r.bg = {1'b0, 4'(lo - SGR_BG_LO)};
				SGR_BG_DEF:             r.bg = COLOUR_DEF;
				[SGR_FGB_LO:SGR_FGB_HI]: r.fg = 5'(lo - SGR_FGB_LO) + 5'd8;
				[SGR_BGB_LO:SGR_BGB_HI]: r.bg = 5'(lo - SGR_BGB_LO) + 5'd8;
				default: ;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/ansi_sgr_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ANSI SGR stream decoder unit
// Decodes a terminal byte stream: held CR, escape/CSI parsing, SGR style
// updates and screen-clear events; emits printable bytes with their style.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | byte_in
//  out     | out_valid / out_ready| kind, char_out, fg_colour, bg_colour,
//          |                      | bold_on, last
//
//  One byte accepted per cycle while the input is not stalled.
//  Decode is one pass from the input register into a four-entry result queue.
//  A byte giving two results emits them one at a time; the queue absorbs them.
//  Input stalls only while the queue holds more than two results.
//  Reset: normal text mode, default style, no CR held, queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ansi_sgr_stream_decoder_unit
	import asgr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic [7:0]      char_out,
	output logic [4:0]      fg_colour,
	output logic [4:0]      bg_colour,
	output logic            bold_on,
	output logic            last
);

	// input register
	logic [7:0]         byte_s1;
	logic               vld_s1;

	// parser state
	mode_t              mode_q, mode_d;
	logic               cr_q, cr_d;
	style_t             cur_q, cur_d;
	style_t             new_q, new_d;
	logic [FIELD_W-1:0] fval_q, fval_d;
	logic               fovf_q, fovf_d;
	logic               two_q, two_d;

	// result queue
	res_t               fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               proc_fire, pop;
	logic [1:0]         nres;
	res_t               r0, r1;

	logic               is_digit, do_normal, add_dig, end_fld, commit, drop, clr_fld;
	logic [PROD_W-1:0]  prod;
	style_t             applied;

	assign proc_fire = vld_s1 && (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign in_ready  = !vld_s1 || proc_fire;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign prod     = ({4'b0, fval_q} << 3) + ({4'b0, fval_q} << 1)
		+ PROD_W'(byte_s1 - CH_ZERO);
	assign applied  = asgr_apply(new_q, fovf_q ? '0 : fval_q);

	// next parse mode
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_NORMAL: mode_d = (byte_s1 == CH_ESC) ? MODE_ESC : MODE_NORMAL;
			MODE_ESC: begin
				if (byte_s1 == CH_LBRACK)
					mode_d = MODE_CSI;
				else if (byte_s1 == CH_ESC)
					mode_d = MODE_ESC;
				else
					mode_d = MODE_NORMAL;
			end
			MODE_CSI, MODE_PARAMS: begin
				if (is_digit || byte_s1 == CH_SEMI)
					mode_d = MODE_PARAMS;
				else
					mode_d = MODE_NORMAL;
			end
			default: mode_d = MODE_NORMAL;
		endcase
	end

	// actions and results
	always_comb begin
		do_normal = 1'b0;
		add_dig   = 1'b0;
		end_fld   = 1'b0;
		commit    = 1'b0;
		drop      = 1'b0;
		clr_fld   = 1'b0;
		cr_d      = cr_q;
		cur_d     = cur_q;
		new_d     = new_q;
		fval_d    = fval_q;
		fovf_d    = fovf_q;
		two_d     = two_q;
		nres      = 2'd0;
		r0        = '{kind: KIND_CHAR, ch: CH_NUL, style: cur_q, last: 1'b0};
		r1        = '{kind: KIND_CHAR, ch: CH_NUL, style: cur_q, last: 1'b1};

		unique case (mode_q)
			MODE_ESC: begin
				if (byte_s1 == CH_LBRACK) begin
					new_d   = cur_q;
					clr_fld = 1'b1;
				end else begin
					do_normal = 1'b1;
				end
			end
			MODE_CSI, MODE_PARAMS: begin
				if (is_digit) begin
					add_dig = 1'b1;
					two_d   = (mode_q == MODE_CSI) && (byte_s1 == CH_TWO);
				end else if (byte_s1 == CH_SEMI) begin
					end_fld = 1'b1;
				end else if (byte_s1 == CH_M) begin
					end_fld = 1'b1;
					commit  = 1'b1;
				end else if (mode_q == MODE_PARAMS && byte_s1 == CH_J && two_q) begin
					drop    = 1'b1;
					r0.kind = KIND_CLEAR;
					nres    = 2'd1;
				end else begin
					drop = 1'b1;
				end
			end
			default: do_normal = 1'b1;
		endcase

		if (add_dig && !fovf_q) begin
			if (prod[PROD_W-1:FIELD_W] != '0) begin
				fovf_d = 1'b1;
				fval_d = '0;
			end else begin
				fval_d = prod[FIELD_W-1:0];
			end
		end
		if (end_fld) begin
			new_d   = applied;
			clr_fld = 1'b1;
		end
		if (commit)
			cur_d = applied;
		if (drop) begin
			new_d   = cur_q;
			clr_fld = 1'b1;
		end
		if (clr_fld) begin
			fval_d = '0;
			fovf_d = 1'b0;
			two_d  = 1'b0;
		end

		if (do_normal && byte_s1 != CH_ESC) begin
			if (byte_s1 == CH_CR) begin
				if (cr_q) begin
					r0.ch = CH_CR;
					nres  = 2'd1;
				end
				cr_d = 1'b1;
			end else begin
				if (cr_q) begin
					r0.ch = CH_CR;
					r1.ch = byte_s1;
					nres  = 2'd2;
				end else begin
					r0.ch = byte_s1;
					nres  = 2'd1;
				end
				cr_d = 1'b0;
			end
		end

		r0.last = (nres == 2'd1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			mode_q <= MODE_NORMAL;
			cr_q   <= 1'b0;
			cur_q  <= '{fg: COLOUR_DEF, bg: COLOUR_DEF, bold: 1'b0};
			new_q  <= '{fg: COLOUR_DEF, bg: COLOUR_DEF, bold: 1'b0};
			fval_q <= '0;
			fovf_q <= 1'b0;
			two_q  <= 1'b0;
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (proc_fire) begin
				mode_q <= mode_d;
				cr_q   <= cr_d;
				cur_q  <= cur_d;
				new_q  <= new_d;
				fval_q <= fval_d;
				fovf_q <= fovf_d;
				two_q  <= two_d;
				wr_q   <= wr_q + PTR_W'(nres);
			end
			if (pop)
				rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (proc_fire ? CNT_W'(nres) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= byte_in;
		if (proc_fire && nres != 2'd0)
			fifo_q[wr_q] <= r0;
		if (proc_fire && nres == 2'd2)
			fifo_q[wr_q + PTR_W'(1)] <= r1;
	end

	assign kind      = fifo_q[rd_q].kind;
	assign char_out  = fifo_q[rd_q].ch;
	assign fg_colour = fifo_q[rd_q].style.fg;
	assign bg_colour = fifo_q[rd_q].style.bg;
	assign bold_on   = fifo_q[rd_q].style.bold;
	assign last      = fifo_q[rd_q].last;

endmodule

`default_nettype wire

[design/asgr_checker.sv]
// ----------------------------------------------------------------------------
// ANSI SGR stream decoder checker
// Port-level checks on the decoder input and result streams, bound to the decoder unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_sgr_stream_decoder_unit_defines.svh"

module asgr_checker
	import asgr_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] byte_in,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       kind,
	input wire logic [7:0] char_out,
	input wire logic [4:0] fg_colour,
	input wire logic [4:0] bg_colour,
	input wire logic       bold_on,
	input wire logic       last
);

	logic        in_stall;
	logic        out_stall;
	logic        colour_ok;
	logic        pair_ok;
	logic [20:0] res_bus;

	assign in_stall  = in_valid && !in_ready;
	assign out_stall = out_valid && !out_ready;
	assign colour_ok = (fg_colour <= COLOUR_DEF) && (bg_colour <= COLOUR_DEF);
	assign pair_ok   = (kind == KIND_CHAR) && (char_out == CH_CR);
	assign res_bus   = {kind, char_out, fg_colour, bg_colour, bold_on, last};

	// offered byte holds while stalled
	`ASGR_ASSERT_NEXT(a_in_hold, clk, arst_n, in_stall, in_valid && $stable(byte_in))

	// stalled result holds
	`ASGR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(res_bus))

	// screen clear is a single result with a null character
	`ASGR_ASSERT_NOW(a_clear_form, clk, arst_n, out_valid && kind == KIND_CLEAR, last && char_out == CH_NUL)

	// colours stay in the palette or default
	`ASGR_ASSERT_NOW(a_colour_range, clk, arst_n, out_valid, colour_ok)

	// first of a result pair is always the held carriage return
	`ASGR_ASSERT_NOW(a_pair_cr, clk, arst_n, out_valid && !last, pair_ok)

endmodule

bind ansi_sgr_stream_decoder_unit asgr_checker u_asgr_checker (.*);

`default_nettype wire

[tb/ansi_sgr_stream_decoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR stream decoder checker
// Watches both channels of the decoder. Every accepted byte is run through a
// behavioral decoder (held CR, escape/CSI parsing, SGR style fields, screen
// clear) and the items it owes are queued; every accepted output item is
// compared field by field with the oldest owed item.
// ----------------------------------------------------------------------------

module ansi_sgr_stream_decoder_checker
	import asgr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       kind,
	input  logic [7:0] char_out,
	input  logic [4:0] fg_colour,
	input  logic [4:0] bg_colour,
	input  logic       bold_on,
	input  logic       last,
	output int         fail_count,
	output int         owed_count,
	output int         chars_seen,
	output int         clears_seen
);

	localparam longint unsigned FIELD_LIMIT = 64'h7FFF_FFFF;

	mode_t              mode;
	logic               cr_held;
	style_t             cur_sty;
	style_t             pend_sty;
	logic [FIELD_W-1:0] fld_val;
	logic               fld_ovf;
	logic               fld_two;

	res_t owed_q[$];
	res_t want;
	int   fails;
	int   n_chars;
	int   n_clears;

	function automatic style_t sgr_update(input style_t s, input logic [FIELD_W-1:0] v);
		style_t      r;
		int unsigned c;
		r = s;
		c = v;
		if (c == SGR_RESET) begin
			r.fg   = COLOUR_DEF;
			r.bg   = COLOUR_DEF;
			r.bold = 1'b0;
		end else if (c == SGR_BOLD) begin
			r.bold = 1'b1;
		end else if (c >= SGR_FG_LO && c <= SGR_FG_HI) begin
			r.fg = 5'(c - SGR_FG_LO);
		end else if (c == SGR_FG_DEF) begin
			r.fg = COLOUR_DEF;
		end else if (c >= SGR_BG_LO && c <= SGR_BG_HI) begin
			r.bg = 5'(c - SGR_BG_LO);
		end else if (c == SGR_BG_DEF) begin
			r.bg = COLOUR_DEF;
		end else if (c >= SGR_FGB_LO && c <= SGR_FGB_HI) begin
			r.fg = 5'(c - SGR_FGB_LO + 8);
		end else if (c >= SGR_BGB_LO && c <= SGR_BGB_HI) begin
			r.bg = 5'(c - SGR_BGB_LO + 8);
		end
		return r;
	endfunction

	function automatic res_t make_item(input logic k, input logic [7:0] c);
		res_t r;
		r.kind  = k;
		r.ch    = c;
		r.style = cur_sty;
		r.last  = 1'b0;
		return r;
	endfunction

	task automatic field_clear();
		fld_val = '0;
		fld_ovf = 1'b0;
		fld_two = 1'b0;
	endtask

	task automatic field_close();
		pend_sty = sgr_update(pend_sty, fld_ovf ? '0 : fld_val);
		field_clear();
	endtask

	task automatic field_digit(input logic [7:0] b);
		longint unsigned nv;
		if (!fld_ovf) begin
			nv = longint'(fld_val) * 10 + longint'(b - CH_ZERO);
			if (nv > FIELD_LIMIT) begin
				fld_ovf = 1'b1;
				fld_val = '0;
			end else begin
				fld_val = nv[FIELD_W-1:0];
			end
		end
	endtask

	task automatic pend_drop();
		pend_sty = cur_sty;
		field_clear();
		mode = MODE_NORMAL;
	endtask

	task automatic pend_commit();
		cur_sty = pend_sty;
		field_clear();
		mode = MODE_NORMAL;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		res_t made[2];
		res_t r;
		int   n;
		logic dig;
		logic as_text;
		n       = 0;
		as_text = 1'b0;
		dig     = (b >= CH_ZERO) && (b <= CH_NINE);
		case (mode)
		MODE_ESC: begin
			if (b == CH_LBRACK) begin
				pend_sty = cur_sty;
				field_clear();
				mode = MODE_CSI;
			end else begin
				// lone ESC: drop it, byte goes back through text handling
				mode    = MODE_NORMAL;
				as_text = 1'b1;
			end
		end
		MODE_CSI: begin
			if (dig) begin
				field_digit(b);
				fld_two = (b == CH_TWO);
				mode    = MODE_PARAMS;
			end else if (b == CH_SEMI) begin
				field_close();
				mode = MODE_PARAMS;
			end else if (b == CH_M) begin
				field_close();
				pend_commit();
			end else begin
				pend_drop();
			end
		end
		MODE_PARAMS: begin
			if (dig) begin
				field_digit(b);
				fld_two = 1'b0;
			end else if (b == CH_SEMI) begin
				field_close();
			end else if (b == CH_M) begin
				field_close();
				pend_commit();
			end else if (b == CH_J && fld_two) begin
				pend_drop();
				made[n] = make_item(KIND_CLEAR, CH_NUL);
				n++;
			end else begin
				pend_drop();
			end
		end
		default: as_text = 1'b1;
		endcase
		if (as_text) begin
			if (b == CH_ESC) begin
				mode = MODE_ESC;
			end else begin
				if (cr_held) begin
					made[n] = make_item(KIND_CHAR, CH_CR);
					n++;
				end
				cr_held = (b == CH_CR);
				if (b != CH_CR) begin
					made[n] = make_item(KIND_CHAR, b);
					n++;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			r      = made[i];
			r.last = (i == n - 1);
			owed_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode     = MODE_NORMAL;
			cr_held  = 1'b0;
			cur_sty  = {COLOUR_DEF, COLOUR_DEF, 1'b0};
			pend_sty = cur_sty;
			field_clear();
			owed_q.delete();
			fails    = 0;
			n_chars  = 0;
			n_clears = 0;
			fail_count  <= 0;
			owed_count  <= 0;
			chars_seen  <= 0;
			clears_seen <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(byte_in);
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$error("item with none owed: kind %0b char_out %0h", kind, char_out);
					fails++;
				end else begin
					want = owed_q.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0b, got %0b", want.kind, kind);
						fails++;
					end
					if (char_out !== want.ch) begin
						$error("char_out: expected %0h, got %0h", want.ch, char_out);
						fails++;
					end
					if (fg_colour !== want.style.fg) begin
						$error("fg_colour: expected %0d, got %0d", want.style.fg, fg_colour);
						fails++;
					end
					if (bg_colour !== want.style.bg) begin
						$error("bg_colour: expected %0d, got %0d", want.style.bg, bg_colour);
						fails++;
					end
					if (bold_on !== want.style.bold) begin
						$error("bold_on: expected %0b, got %0b", want.style.bold, bold_on);
						fails++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						fails++;
					end
					if (want.kind == KIND_CLEAR)
						n_clears++;
					else
						n_chars++;
				end
			end
			fail_count  <= fails;
			owed_count  <= owed_q.size();
			chars_seen  <= n_chars;
			clears_seen <= n_clears;
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR stream decoder testbench
// Feeds the decoder a short directed byte stream and then random terminal
// traffic (text, held CRs, SGR sequences with odd fields, clears, cursor
// home, lone escapes, noise) with random gaps on both channels, a long
// output hold-off and full drain pauses. The checker does the comparing.
// ----------------------------------------------------------------------------

module tb_top;
	import asgr_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 2000;
	localparam int TAIL_CYCLES  = 20;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] byte_in   = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       kind;
	logic [7:0] char_out;
	logic [4:0] fg_colour;
	logic [4:0] bg_colour;
	logic       bold_on;
	logic       last;

	int fail_count;
	int owed_count;
	int chars_seen;
	int clears_seen;

	logic [7:0] feed_q[$];
	int         bytes_sent  = 0;
	int         drain_at    = 0;
	int         idle_cycles = 0;
	logic       burst       = 1'b0;

	always #1 clk = ~clk;

	ansi_sgr_stream_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.char_out  (char_out),
		.fg_colour (fg_colour),
		.bg_colour (bg_colour),
		.bold_on   (bold_on),
		.last      (last)
	);

	ansi_sgr_stream_decoder_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_in     (byte_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.char_out    (char_out),
		.fg_colour   (fg_colour),
		.bg_colour   (bg_colour),
		.bold_on     (bold_on),
		.last        (last),
		.fail_count  (fail_count),
		.owed_count  (owed_count),
		.chars_seen  (chars_seen),
		.clears_seen (clears_seen)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] odd_final();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_M)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic put(input logic [7:0] b);
		feed_q.push_back(b);
	endtask

	task automatic put_num(input int unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_csi();
		put(CH_ESC);
		put(CH_LBRACK);
	endtask

	task automatic add_sgr();
		int nf;
		int pick;
		int nd;
		nf = $urandom_range(1, 4);
		put_csi();
		for (int f = 0; f < nf; f++) begin
			pick = $urandom_range(0, 9);
			case (pick)
			0: ;
			1: put_num($urandom_range(SGR_RESET, SGR_BOLD));
			2: put_num($urandom_range(SGR_FG_LO, SGR_FG_HI));
			3: put_num($urandom_range(SGR_BG_LO, SGR_BG_HI));
			4: put_num($urandom_range(SGR_FGB_LO, SGR_FGB_HI));
			5: put_num($urandom_range(SGR_BGB_LO, SGR_BGB_HI));
			6: put_num($urandom_range(0, 1) ? SGR_FG_DEF : SGR_BG_DEF);
			7: put_num($urandom_range(0, 999));
			8: begin
				// long digit runs, most past the field limit
				nd = $urandom_range(10, 13);
				put(8'(CH_ZERO + $urandom_range(1, 9)));
				for (int i = 1; i < nd; i++)
					put(8'(CH_ZERO + $urandom_range(0, 9)));
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					put(CH_ZERO);
					put(CH_ZERO);
					put_num($urandom_range(SGR_RESET, SGR_BGB_HI));
				end else begin
					put_num(32'd2147483647 + $urandom_range(0, 1));
				end
			end
			endcase
			if (f < nf - 1)
				put(CH_SEMI);
		end
		if ($urandom_range(0, 19) < 18)
			put(CH_M);
		else
			put(odd_final());
	endtask

	task automatic add_text();
		int n;
		int pick;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				put(8'($urandom_range(CH_SPACE, CH_TILDE)));
			else if (pick == 7)
				put(CH_LF);
			else if (pick == 8)
				put(CH_CR);
			else
				put(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_cr();
		put(CH_CR);
		case ($urandom_range(0, 4))
		0: put(CH_CR);
		1: put(CH_LF);
		2: put(8'($urandom_range(CH_SPACE, CH_TILDE)));
		3: begin
			// held CR across a style change
			add_sgr();
			add_text();
		end
		default: begin
			put(CH_CR);
			put(CH_CR);
			put(CH_LF);
		end
		endcase
	endtask

	task automatic add_clear();
		put_csi();
		case ($urandom_range(0, 9))
		6: begin
			put(CH_TWO);
			put(CH_TWO);
		end
		7: begin
			put_num(SGR_BOLD);
			put(CH_SEMI);
			put(CH_TWO);
		end
		8: begin
			put(CH_TWO);
			put(CH_SEMI);
		end
		9: put(8'(CH_ZERO + 3));
		default: put(CH_TWO);
		endcase
		put(CH_J);
	endtask

	task automatic add_lone();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_LBRACK)
			b = CH_H;
		put(CH_ESC);
		put(b);
	endtask

	task automatic add_chunk();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			add_sgr();
		end else if (pick < 60) begin
			add_text();
		end else if (pick < 70) begin
			add_cr();
		end else if (pick < 78) begin
			add_clear();
		end else if (pick < 82) begin
			put_csi();
			put(CH_H);
		end else if (pick < 90) begin
			add_lone();
		end else begin
			repeat ($urandom_range(1, 4))
				put(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_item(input logic [7:0] b, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
	endtask

	task automatic play_feed();
		int g;
		while (feed_q.size() != 0) begin
			if (bytes_sent % 128 == 0)
				burst = ($urandom_range(0, 3) == 0);
			g = burst ? 0 : gap_len();
			send_item(feed_q.pop_front(), g);
			bytes_sent++;
			if (bytes_sent == drain_at)
				drain_wait();
		end
	endtask

	initial begin : tx_side
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put(8'h00);
		put(8'hFF);
		put(CH_CR);
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put_csi();
		put_num(SGR_BOLD);
		put(CH_M);
		put("A");
		put(CH_ESC);
		put("Z");
		put_csi();
		put(CH_M);
		put_csi();
		put(8'(CH_ZERO + 4));
		put("x");
		put_csi();
		put(CH_TWO);
		put(CH_J);
		put_csi();
		put(CH_H);
		play_feed();
		drain_wait();

		drain_at = bytes_sent + RANDOM_BYTES / 2;
		while (bytes_sent < drain_at + RANDOM_BYTES / 2) begin
			add_chunk();
			play_feed();
		end

		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d bytes: text, held CR, SGR fields, clears, home, lone ESC, noise.",
			bytes_sent);
		$display("Checked %0d styled characters and %0d screen clears.", chars_seen,
			clears_seen);
		if (fail_count == 0 && owed_count == 0) begin
			$display("PASS ansi_sgr_stream_decoder_unit");
		end else begin
			$display("FAIL ansi_sgr_stream_decoder_unit");
		end
		$finish;
	end

	initial begin : rx_side
		int   rcv_cyc;
		int   hold_left;
		int   run_left;
		logic run_ready;
		rcv_cyc   = 0;
		hold_left = 0;
		run_left  = 0;
		run_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			rcv_cyc++;
			if (rcv_cyc % 2500 == 600)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_ready = !run_ready;
					if (run_ready) begin
						run_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
					end else begin
						run_left = gap_len();
						if (run_left == 0) begin
							run_ready = 1'b1;
							run_left  = $urandom_range(1, 30);
						end
					end
				end
				run_left--;
				out_ready <= run_ready;
			end
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL ansi_sgr_stream_decoder_unit");
			$finish;
		end
	end

endmodule

[ansi_sgr_stream_decoder_unit.f]
+incdir+design
design/asgr_pkg.sv
design/ansi_sgr_stream_decoder_unit.sv
design/asgr_checker.sv
tb/ansi_sgr_stream_decoder_checker.sv
tb/tb_top.sv
